// File: hw/rtl/isc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort package
// Shared sizes, payload types and control groups of the insertion sorter.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned MAX_ITEMS = 32;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CMP_W     = 10;
  localparam int unsigned SHF_W     = 9;
  localparam int unsigned GT_CNT_W  = $clog2(MAX_ITEMS + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic unload;
    logic clear;
  } cell_ctrl_t;

  // Commands to the counter stage.
  typedef struct packed {
    logic upd;
    logic first;
    logic clear;
  } cnt_ctrl_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SETTLE,
    ST_EMIT
  } isc_state_e;

endpackage

// File: hw/rtl/isc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one word of the sorted run and moves it up on insertion or down on
// unload.
// ----------------------------------------------------------------------------
module isc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isc_pkg::cell_ctrl_t ctrl_i,
  input  isc_pkg::word_t     word_i,
  input  logic               prev_gt_i,
  input  logic               prev_vld_i,
  input  isc_pkg::word_t     prev_data_i,
  input  logic               next_vld_i,
  input  isc_pkg::word_t     next_data_i,
  output logic               gt_o,
  output logic               vld_o,
  output isc_pkg::word_t     data_o
);
  import isc_pkg::*;

  word_t data_q, data_d;
  logic  vld_q, vld_d;
  logic  take_prev;
  logic  take_word;

  assign gt_o   = vld_q && (data_q > word_i);
  assign vld_o  = vld_q;
  assign data_o = data_q;

  // The cell below holds a greater word, so that word moves up into this one.
  // The first cell that holds a greater word, or the first empty one, takes
  // the new word.
  assign take_prev = prev_gt_i;
  assign take_word = !prev_gt_i && prev_vld_i && (gt_o || !vld_q);

  always_comb begin
    data_d = data_q;
    vld_d  = vld_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.unload) begin
      data_d = next_data_i;
      vld_d  = next_vld_i;
    end else if (ctrl_i.insert) begin
      if (take_prev) begin
        data_d = prev_data_i;
        vld_d  = 1'b1;
      end else if (take_word) begin
        data_d = word_i;
        vld_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/isc_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort counters
// Adds up the shifts and comparisons of each insertion in the cycle after it.
// ----------------------------------------------------------------------------
module isc_count (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  isc_pkg::cnt_ctrl_t                ctrl_i,
  input  logic [isc_pkg::MAX_ITEMS-1:0]     gt_i,
  output logic [isc_pkg::CMP_W-1:0]         cmp_total_o,
  output logic [isc_pkg::SHF_W-1:0]         shf_total_o
);
  import isc_pkg::*;

  localparam logic [CMP_W:0] CmpMax = (CMP_W+1)'((1 << CMP_W) - 1);
  localparam logic [SHF_W:0] ShfMax = (SHF_W+1)'((1 << SHF_W) - 1);

  logic                 upd_q;
  logic                 first_q;
  logic [MAX_ITEMS-1:0] gt_q;
  logic [GT_CNT_W-1:0]  greater;
  logic [CMP_W:0]       cmp_sum;
  logic [SHF_W:0]       shf_sum;
  logic [CMP_W-1:0]     cmp_q, cmp_d;
  logic [SHF_W-1:0]     shf_q, shf_d;

  assign greater = GT_CNT_W'($countones(gt_q));
  assign shf_sum = (SHF_W+1)'(shf_q) + (SHF_W+1)'(greater);
  assign cmp_sum = (CMP_W+1)'(cmp_q) + (CMP_W+1)'(greater) + (CMP_W+1)'(!first_q);

  always_comb begin
    cmp_d = cmp_q;
    shf_d = shf_q;
    if (ctrl_i.clear) begin
      cmp_d = '0;
      shf_d = '0;
    end else if (upd_q) begin
      cmp_d = (cmp_sum > CmpMax) ? CmpMax[CMP_W-1:0] : cmp_sum[CMP_W-1:0];
      shf_d = (shf_sum > ShfMax) ? ShfMax[SHF_W-1:0] : shf_sum[SHF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= 1'b0;
      cmp_q <= '0;
      shf_q <= '0;
    end else begin
      upd_q <= ctrl_i.upd && !ctrl_i.clear;
      cmp_q <= cmp_d;
      shf_q <= shf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gt_q    <= gt_i;
    first_q <= ctrl_i.first;
  end

  assign cmp_total_o = cmp_q;
  assign shf_total_o = shf_q;

endmodule

// File: hw/rtl/insertion_sort_with_counts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort with counts
// Stable ascending sorter built as a chain of compare-and-hold cells.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while the set fills; every cell compares its
// word with the incoming one at once through the parallel cell comparators.
// A word that arrives while all MAX_ITEMS cells are full is dropped and
// flagged. After the request marked final, the settle state lets the counter
// stage catch up, then the run leaves from the bottom cell at one result per
// cycle while the output is not stalled and the chain shifts down. The next
// set is accepted in the cycle after the last result of the run is taken.
module insertion_sort_with_counts (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            value_i,
  input  logic                          final_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            sorted_value_o,
  output logic                          run_end_o,
  output logic [isc_pkg::CMP_W-1:0]     comparison_total_o,
  output logic [isc_pkg::SHF_W-1:0]     shift_total_o,
  output logic                          overflowed_o
);
  import isc_pkg::*;

  isc_state_e           state_q, state_d;
  logic                 drop_q, drop_d;
  logic                 in_acc;
  logic                 out_acc;
  logic                 full;
  cell_ctrl_t           cell_ctrl;
  cnt_ctrl_t            cnt_ctrl;
  logic [MAX_ITEMS-1:0] cell_gt;
  logic [MAX_ITEMS-1:0] cell_vld;
  word_t                cell_data [MAX_ITEMS];

  assign full    = cell_vld[MAX_ITEMS-1];
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic  prev_gt;
    logic  prev_vld;
    word_t prev_data;
    logic  next_vld;
    word_t next_data;

    if (i == 0) begin : g_first
      assign prev_gt   = 1'b0;
      assign prev_vld  = 1'b1;
      assign prev_data = '0;
    end else begin : g_mid
      assign prev_gt   = cell_gt[i-1];
      assign prev_vld  = cell_vld[i-1];
      assign prev_data = cell_data[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_vld  = 1'b0;
      assign next_data = '0;
    end else begin : g_inner
      assign next_vld  = cell_vld[i+1];
      assign next_data = cell_data[i+1];
    end

    isc_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .word_i      (value_i[WORD_BITS-1:0]),
      .prev_gt_i   (prev_gt),
      .prev_vld_i  (prev_vld),
      .prev_data_i (prev_data),
      .next_vld_i  (next_vld),
      .next_data_i (next_data),
      .gt_o        (cell_gt[i]),
      .vld_o       (cell_vld[i]),
      .data_o      (cell_data[i])
    );
  end

  isc_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cnt_ctrl),
    .gt_i        (cell_gt),
    .cmp_total_o (comparison_total_o),
    .shf_total_o (shift_total_o)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: begin
        if (in_acc && final_item_i) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && run_end_o) begin
          state_d = ST_FILL;
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_stall_o       = (state_q != ST_FILL);
    out_valid_o      = (state_q == ST_EMIT);
    cell_ctrl.insert = in_acc && !full;
    cell_ctrl.unload = out_acc && !run_end_o;
    cell_ctrl.clear  = out_acc && run_end_o;
    cnt_ctrl.upd     = in_acc && !full;
    cnt_ctrl.first   = !cell_vld[0];
    cnt_ctrl.clear   = out_acc && run_end_o;
  end

  always_comb begin
    drop_d = drop_q;
    if (cell_ctrl.clear) begin
      drop_d = 1'b0;
    end else if (in_acc && full) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  assign sorted_value_o = 32'(cell_data[0]);
  assign run_end_o      = !cell_vld[1];
  assign overflowed_o   = drop_q;

  // Occupied cells always form an unbroken run from the bottom of the chain.
  a_vld_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld & (cell_vld + 1'b1)) == '0)
    else $error("occupied cells are not contiguous");

  a_emit_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_vld[0])
    else $error("result offered from an empty cell");

  a_final_settles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && final_item_i |=> state_q == ST_SETTLE && cell_vld[0])
    else $error("final request did not start the run");

  a_run_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !run_end_o |=> sorted_value_o >= $past(sorted_value_o))
    else $error("run is not ascending");

endmodule
